>>> sv/adpu_pkg.sv
// Shared types, opcode codes and queue sizing for the data-processing unit.
package adpu_pkg;

    // Instruction field positions
    localparam int unsigned BIT_I = 25;
    localparam int unsigned BIT_S = 20;

    // Data-processing opcodes, instruction bits 24..21
    localparam logic [3:0] OPC_AND = 4'd0;
    localparam logic [3:0] OPC_EOR = 4'd1;
    localparam logic [3:0] OPC_SUB = 4'd2;
    localparam logic [3:0] OPC_RSB = 4'd3;
    localparam logic [3:0] OPC_ADD = 4'd4;
    localparam logic [3:0] OPC_TST = 4'd8;
    localparam logic [3:0] OPC_TEQ = 4'd9;
    localparam logic [3:0] OPC_CMP = 4'd10;
    localparam logic [3:0] OPC_ORR = 4'd12;
    localparam logic [3:0] OPC_MOV = 4'd13;

    // Shift types, instruction bits 6..5
    localparam logic [1:0] SHT_LSL = 2'd0;
    localparam logic [1:0] SHT_LSR = 2'd1;
    localparam logic [1:0] SHT_ASR = 2'd2;
    localparam logic [1:0] SHT_ROR = 2'd3;

    // Queue between decode and execute
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        ALU_AND  = 3'd0,
        ALU_EOR  = 3'd1,
        ALU_SUB  = 3'd2,
        ALU_RSB  = 3'd3,
        ALU_ADD  = 3'd4,
        ALU_ORR  = 3'd5,
        ALU_MOV  = 3'd6,
        ALU_NONE = 3'd7
    } alu_op_t;

    // One decoded instruction with its operand 2 already shifted
    typedef struct packed {
        logic [31:0] rn;
        logic [31:0] op2;       // shifter output, bit 31 clear for RRX
        logic        sh_carry;  // shifter carry out
        logic        keep_c;    // carry out is the old C flag
        logic        rrx;       // old C flag goes into bit 31 of op2
        alu_op_t     alu_op;
        logic        write;
        logic        logical;
        logic        bad;
        logic        sbit;
        logic [3:0]  rd;
    } dp_item_t;

endpackage

>>> sv/adpu_front.sv
// Decode and barrel shifter: classifies the instruction and forms operand 2.
module adpu_front
    import adpu_pkg::*;
(
    input  logic [31:0] instruction,
    input  logic [31:0] first_operand_value,
    input  logic [31:0] shifted_register_value,
    input  logic [31:0] shift_amount_register_value,
    output dp_item_t    item
);

    logic [3:0]  opcode;
    logic [4:0]  rot;
    logic [31:0] imm32;
    logic [1:0]  sh_type;
    logic [7:0]  amt;
    logic [31:0] v;
    logic [32:0] lsl_w;
    logic [32:0] lsr_w;
    logic [32:0] asr_w;
    logic [31:0] ror_v;

    assign opcode  = instruction[24:21];
    assign rot     = {instruction[11:8], 1'b0};
    assign imm32   = {24'd0, instruction[7:0]};
    assign sh_type = instruction[6:5];
    assign v       = shifted_register_value;

    // Resolve the shift amount; immediate LSR/ASR #0 means 32
    always_comb
    begin
        if (instruction[4])
        begin
            amt = shift_amount_register_value[7:0];
        end
        else if (instruction[11:7] == 5'd0 &&
                 (sh_type == SHT_LSR || sh_type == SHT_ASR))
        begin
            amt = 8'd32;
        end
        else
        begin
            amt = {3'd0, instruction[11:7]};
        end
    end

    assign lsl_w = {1'b0, v} << amt[4:0];
    assign lsr_w = {v, 1'b0} >> amt[4:0];
    assign asr_w = 33'($signed({v, 1'b0}) >>> amt[4:0]);
    assign ror_v = (v >> amt[4:0]) | (v << (6'd32 - {1'b0, amt[4:0]}));

    always_comb
    begin
        item.rn       = first_operand_value;
        item.rd       = instruction[15:12];
        item.sbit     = instruction[BIT_S];
        item.op2      = v;
        item.sh_carry = 1'b0;
        item.keep_c   = 1'b0;
        item.rrx      = 1'b0;

        if (instruction[BIT_I])
        begin
            item.op2      = (imm32 >> rot) | (imm32 << (6'd32 - {1'b0, rot}));
            item.sh_carry = item.op2[31];
            item.keep_c   = (rot == 5'd0);
        end
        else if (!instruction[4] && instruction[11:7] == 5'd0 && sh_type == SHT_ROR)
        begin
            // rotate right by one through carry
            item.op2      = {1'b0, v[31:1]};
            item.sh_carry = v[0];
            item.rrx      = 1'b1;
        end
        else if (amt == 8'd0)
        begin
            item.keep_c = 1'b1;
        end
        else
        begin
            unique case (sh_type)
                SHT_LSL:
                begin
                    if (amt < 8'd32)
                    begin
                        item.op2      = lsl_w[31:0];
                        item.sh_carry = lsl_w[32];
                    end
                    else
                    begin
                        item.op2      = 32'd0;
                        item.sh_carry = (amt == 8'd32) & v[0];
                    end
                end
                SHT_LSR:
                begin
                    if (amt < 8'd32)
                    begin
                        item.op2      = lsr_w[32:1];
                        item.sh_carry = lsr_w[0];
                    end
                    else
                    begin
                        item.op2      = 32'd0;
                        item.sh_carry = (amt == 8'd32) & v[31];
                    end
                end
                SHT_ASR:
                begin
                    if (amt < 8'd32)
                    begin
                        item.op2      = asr_w[32:1];
                        item.sh_carry = asr_w[0];
                    end
                    else
                    begin
                        item.op2      = {32{v[31]}};
                        item.sh_carry = v[31];
                    end
                end
                default:
                begin
                    // ROR: a multiple of 32 leaves the value, carry is bit 31
                    item.op2      = ror_v;
                    item.sh_carry = ror_v[31];
                end
            endcase
        end

        // Classify the opcode
        item.write   = 1'b0;
        item.logical = 1'b0;
        item.bad     = 1'b0;
        unique case (opcode)
            OPC_AND: begin item.alu_op = ALU_AND; item.write = 1'b1; item.logical = 1'b1; end
            OPC_EOR: begin item.alu_op = ALU_EOR; item.write = 1'b1; item.logical = 1'b1; end
            OPC_SUB: begin item.alu_op = ALU_SUB; item.write = 1'b1; end
            OPC_RSB: begin item.alu_op = ALU_RSB; item.write = 1'b1; end
            OPC_ADD: begin item.alu_op = ALU_ADD; item.write = 1'b1; end
            OPC_TST: begin item.alu_op = ALU_AND; item.logical = 1'b1; end
            OPC_TEQ: begin item.alu_op = ALU_EOR; item.logical = 1'b1; end
            OPC_CMP: begin item.alu_op = ALU_SUB; end
            OPC_ORR: begin item.alu_op = ALU_ORR; item.write = 1'b1; item.logical = 1'b1; end
            OPC_MOV: begin item.alu_op = ALU_MOV; item.write = 1'b1; item.logical = 1'b1; end
            default: begin item.alu_op = ALU_NONE; item.bad = 1'b1; end
        endcase
    end

endmodule

>>> sv/adpu_queue.sv
// Short FIFO of decoded items between decode and execute.
module adpu_queue
    import adpu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  dp_item_t push_item,
    output logic     full,
    input  logic     pop,
    output dp_item_t head,
    output logic     empty
);

    dp_item_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop)
        else $error("pop from empty queue");

endmodule

>>> sv/adpu_back.sv
// Execute stage: ALU, status flag register and the result register.
module adpu_back
    import adpu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_item_t    head,
    input  logic        empty,
    output logic        pop,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [31:0] result_value,
    output logic [3:0]  dest_index,
    output logic        write_dest,
    output logic        flag_negative,
    output logic        flag_zero,
    output logic        flag_carry,
    output logic        bad_opcode
);

    logic [2:0]  flags_reg;     // N, Z, C
    logic [2:0]  flags_next;
    logic        valid_reg;
    logic        valid_next;
    logic [31:0] result_reg;
    logic [3:0]  dest_reg;
    logic        write_reg;
    logic        bad_reg;

    logic        cin;
    logic [31:0] b;
    logic        sc;
    logic [31:0] add_a;
    logic [31:0] add_b;
    logic        add_cin;
    logic [32:0] sum;
    logic [31:0] res;
    logic        c;

    assign cin = flags_reg[0];
    assign b   = head.op2 | {head.rrx & cin, 31'd0};
    assign sc  = head.keep_c ? cin : head.sh_carry;

    // Advance when the result register is free or being drained
    assign pop = !empty && (!valid_reg || !result_stall);

    // One adder serves ADD, SUB and RSB; carry out is not-borrow on subtract
    always_comb
    begin
        add_a   = head.rn;
        add_b   = b;
        add_cin = 1'b0;
        if (head.alu_op == ALU_SUB)
        begin
            add_b   = ~b;
            add_cin = 1'b1;
        end
        else if (head.alu_op == ALU_RSB)
        begin
            add_a   = b;
            add_b   = ~head.rn;
            add_cin = 1'b1;
        end
    end

    assign sum = {1'b0, add_a} + {1'b0, add_b} + {32'd0, add_cin};

    always_comb
    begin
        unique case (head.alu_op)
            ALU_AND: res = head.rn & b;
            ALU_EOR: res = head.rn ^ b;
            ALU_ORR: res = head.rn | b;
            ALU_MOV: res = b;
            ALU_SUB,
            ALU_RSB,
            ALU_ADD: res = sum[31:0];
            default: res = 32'd0;
        endcase
        c = head.logical ? sc : sum[32];
    end

    always_comb
    begin
        flags_next = flags_reg;
        if (pop && head.sbit && !head.bad)
        begin
            flags_next = {res[31], (res == 32'd0), c};
        end
        valid_next = valid_reg;
        if (pop)
        begin
            valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= 3'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            flags_reg <= flags_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            result_reg <= res;
            dest_reg   <= head.rd;
            write_reg  <= head.write;
            bad_reg    <= head.bad;
        end
    end

    assign result_valid  = valid_reg;
    assign result_value  = result_reg;
    assign dest_index    = dest_reg;
    assign write_dest    = write_reg;
    assign bad_opcode    = bad_reg;
    assign flag_negative = flags_reg[2];
    assign flag_zero     = flags_reg[1];
    assign flag_carry    = flags_reg[0];

    a_flags_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!pop || !head.sbit || head.bad) |=> (flags_reg == $past(flags_reg)))
        else $error("flags changed without a flag-setting instruction");

    a_bad_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && bad_reg) |-> (!write_reg && result_reg == 32'd0))
        else $error("unsupported opcode produced a write or a result");

    a_pop_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && result_stall) |-> !pop)
        else $error("execute overwrote a stalled result");

endmodule

>>> sv/arm_data_processing_unit.sv
// Top level of the data-processing execute unit: decode, queue and execute.
//
// Executes one data-processing instruction per transfer: operand 2 is a
// rotated 8-bit immediate or Rm shifted LSL/LSR/ASR/ROR (RRX for ROR #0) by
// an immediate or by the low byte of Rs, then AND, EOR, SUB, RSB, ADD, TST,
// TEQ, CMP, ORR or MOV is applied. Each input transfer yields exactly one
// result transfer with the result, Rd, a write enable (clear for test
// opcodes and unsupported ones) and the N, Z, C flags as they stand after
// the instruction; V is not kept. Unsupported opcodes give bad_opcode = 1,
// a zero result and leave the flags alone. The unit sustains one instruction
// per cycle while result_stall is low; each result is registered. The rate
// is set by the execute stage, which applies the ALU and updates the 3-bit
// flag register once per cycle. Decode and the barrel shifter sit in front
// of a two-entry queue, so item_stall rises only when that queue is full,
// and a stalled result does not hold up the next input transfer.
module arm_data_processing_unit
    import adpu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [31:0] instruction,
    input  logic [31:0] first_operand_value,
    input  logic [31:0] shifted_register_value,
    input  logic [31:0] shift_amount_register_value,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [31:0] result_value,
    output logic [3:0]  dest_index,
    output logic        write_dest,
    output logic        flag_negative,
    output logic        flag_zero,
    output logic        flag_carry,
    output logic        bad_opcode
);

    dp_item_t dec_item;
    dp_item_t head;
    logic     q_full;
    logic     q_empty;
    logic     push;
    logic     pop;

    // Decode and shift the incoming instruction
    adpu_front u_front (
        .instruction                 (instruction),
        .first_operand_value         (first_operand_value),
        .shifted_register_value      (shifted_register_value),
        .shift_amount_register_value (shift_amount_register_value),
        .item                        (dec_item)
    );

    // Stall the input side only when the queue is full
    assign item_stall = q_full;
    assign push       = item_valid && !q_full;

    adpu_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (dec_item),
        .full      (q_full),
        .pop       (pop),
        .head      (head),
        .empty     (q_empty)
    );

    // Execute, hold flags and drive the result transfer
    adpu_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .empty         (q_empty),
        .pop           (pop),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result_value  (result_value),
        .dest_index    (dest_index),
        .write_dest    (write_dest),
        .flag_negative (flag_negative),
        .flag_zero     (flag_zero),
        .flag_carry    (flag_carry),
        .bad_opcode    (bad_opcode)
    );

endmodule

>>> sim/tb_arm_data_processing_unit.sv
// Self-checking testbench for arm_data_processing_unit: directed and random instructions.
module tb_arm_data_processing_unit
    import adpu_pkg::*;
();

    // Run shape
    localparam int unsigned RANDOM_ITEMS    = 1600;
    localparam int unsigned PRESSURE_ITEMS  = 40;
    localparam int unsigned HOLD_OFF_CYCLES = 64;
    localparam int unsigned SETTLE_CYCLES   = 8;     // result is registered behind the queue
    localparam int unsigned WATCHDOG_LIMIT  = 2000;  // far above the hold-off plus both gaps
    localparam int unsigned MAX_REPORTS     = 10;

    // The ten opcodes the unit executes; anything else must raise bad_opcode
    localparam logic [3:0] SUPPORTED_OPCODES [10] = '{
        OPC_AND, OPC_EOR, OPC_SUB, OPC_RSB, OPC_ADD,
        OPC_TST, OPC_TEQ, OPC_CMP, OPC_ORR, OPC_MOV
    };

    // One result transfer, in port order
    typedef struct packed {
        logic [31:0] value;
        logic [3:0]  rd;
        logic        write;
        logic        neg;
        logic        zero;
        logic        carry;
        logic        bad;
    } dp_result_t;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    logic [31:0] instruction;
    logic [31:0] first_operand_value;
    logic [31:0] shifted_register_value;
    logic [31:0] shift_amount_register_value;
    logic        result_valid;
    logic        result_stall;
    logic [31:0] result_value;
    logic [3:0]  dest_index;
    logic        write_dest;
    logic        flag_negative;
    logic        flag_zero;
    logic        flag_carry;
    logic        bad_opcode;

    // Results owed by the unit, oldest first
    dp_result_t  predicted_results[$];
    // Our copy of the status register: {N, Z, C}
    logic [2:0]  nzc_flags;
    int unsigned mismatches;
    int unsigned idle_cycles;
    // Knobs shared between the test tasks and the receiver
    logic        hold_off_request;
    logic        quiet_tx;
    logic        quiet_rx;

    arm_data_processing_unit uut (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic logic [31:0] rotate_right(input logic [31:0] v, input logic [4:0] n);
        logic [63:0] twice;
        twice = {v, v} >> n;
        return twice[31:0];
    endfunction

    // Register shift with an already resolved amount; amount 0 passes v and the old C.
    function automatic logic [31:0] barrel_shift(input logic [31:0] v, input logic [1:0] kind,
                                                 input int unsigned amt, input logic cin,
                                                 output logic cout);
        int unsigned rot;
        cout = cin;
        if (amt == 0)
            return v;
        case (kind)
            SHT_LSL:
            begin
                if (amt < 32)
                begin
                    cout = v[32 - amt];
                    return v << amt;
                end
                cout = (amt == 32) ? v[0] : 1'b0;
                return '0;
            end
            SHT_LSR:
            begin
                if (amt < 32)
                begin
                    cout = v[amt - 1];
                    return v >> amt;
                end
                cout = (amt == 32) ? v[31] : 1'b0;
                return '0;
            end
            SHT_ASR:
            begin
                if (amt < 32)
                begin
                    cout = v[amt - 1];
                    return 32'($signed(v) >>> amt);
                end
                cout = v[31];
                return {32{v[31]}};
            end
            default:
            begin
                rot = amt % 32;
                if (rot == 0)
                begin
                    cout = v[31];
                    return v;
                end
                cout = v[rot - 1];
                return rotate_right(v, 5'(rot));
            end
        endcase
    endfunction

    // Operand 2: rotated immediate, or Rm shifted by an immediate or by Rs[7:0]
    function automatic logic [31:0] form_operand2(input logic [31:0] instr, input logic [31:0] rm,
                                                  input logic [31:0] rs, input logic cin,
                                                  output logic cout);
        logic [4:0]  rot;
        logic [31:0] imm;
        logic [1:0]  kind;
        int unsigned amt;
        kind = instr[6:5];
        if (instr[BIT_I])
        begin
            rot  = {instr[11:8], 1'b0};
            imm  = rotate_right({24'b0, instr[7:0]}, rot);
            cout = (rot == 0) ? cin : imm[31];
            return imm;
        end
        // bit 4 picks the amount source; bit 7 is ignored when bit 4 is set
        if (instr[4])
            return barrel_shift(rm, kind, 32'(rs[7:0]), cin, cout);
        amt = 32'(instr[11:7]);
        if (amt != 0)
            return barrel_shift(rm, kind, amt, cin, cout);
        // Immediate amount zero: LSL #0 is a plain pass, LSR/ASR mean #32, ROR means RRX
        case (kind)
            SHT_LSL:
            begin
                cout = cin;
                return rm;
            end
            SHT_ROR:
            begin
                cout = rm[0];
                return {cin, rm[31:1]};
            end
            default:
                return barrel_shift(rm, kind, 32, cin, cout);
        endcase
    endfunction

    // Execute one instruction against our flag copy and advance it
    function automatic dp_result_t execute_instruction(input logic [31:0] instr,
                                                       input logic [31:0] rn,
                                                       input logic [31:0] rm,
                                                       input logic [31:0] rs);
        dp_result_t  r;
        logic [31:0] op2;
        logic [31:0] value;
        logic [32:0] sum;
        logic        shift_carry;
        logic        carry;
        logic        logical;
        logic        write;
        logic        bad;
        op2     = form_operand2(instr, rm, rs, nzc_flags[0], shift_carry);
        value   = '0;
        carry   = nzc_flags[0];
        logical = 1'b0;
        write   = 1'b0;
        bad     = 1'b0;
        case (instr[24:21])
            OPC_AND:
            begin
                value   = rn & op2;
                write   = 1'b1;
                logical = 1'b1;
            end
            OPC_EOR:
            begin
                value   = rn ^ op2;
                write   = 1'b1;
                logical = 1'b1;
            end
            OPC_SUB:
            begin
                value = rn - op2;
                carry = rn >= op2;
                write = 1'b1;
            end
            OPC_RSB:
            begin
                value = op2 - rn;
                carry = op2 >= rn;
                write = 1'b1;
            end
            OPC_ADD:
            begin
                sum   = {1'b0, rn} + {1'b0, op2};
                value = sum[31:0];
                carry = sum[32];
                write = 1'b1;
            end
            OPC_TST:
            begin
                value   = rn & op2;
                logical = 1'b1;
            end
            OPC_TEQ:
            begin
                value   = rn ^ op2;
                logical = 1'b1;
            end
            OPC_CMP:
            begin
                value = rn - op2;
                carry = rn >= op2;
            end
            OPC_ORR:
            begin
                value   = rn | op2;
                write   = 1'b1;
                logical = 1'b1;
            end
            OPC_MOV:
            begin
                value   = op2;
                write   = 1'b1;
                logical = 1'b1;
            end
            default:
                bad = 1'b1;
        endcase
        if (logical)
            carry = shift_carry;
        // Flags move only with S set and a supported opcode
        if (instr[BIT_S] && !bad)
            nzc_flags = {value[31], value == '0, carry};
        r.value = value;
        r.rd    = instr[15:12];
        r.write = write;
        r.neg   = nzc_flags[2];
        r.zero  = nzc_flags[1];
        r.carry = nzc_flags[0];
        r.bad   = bad;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Build a data-processing word; condition and Rn index are don't-care, so randomize them
    function automatic logic [31:0] dp_word(input logic imm, input logic [3:0] opc,
                                            input logic s, input logic [3:0] rd,
                                            input logic [11:0] op2);
        logic [31:0] w;
        w          = $urandom;
        w[27:26]   = 2'b00;
        w[BIT_I]   = imm;
        w[24:21]   = opc;
        w[BIT_S]   = s;
        w[15:12]   = rd;
        w[11:0]    = op2;
        return w;
    endfunction

    function automatic logic [11:0] shift_by_imm(input logic [4:0] amt, input logic [1:0] kind);
        return {amt, kind, 1'b0, 4'($urandom)};
    endfunction

    function automatic logic [11:0] shift_by_reg(input logic [1:0] kind);
        return {4'($urandom), 1'b0, kind, 1'b1, 4'($urandom)};
    endfunction

    // Register values weighted toward the corners of the 32-bit range
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4:       return 32'h1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    // Rs with its low byte steered to zero, the 32 boundary, in-range and far out of range
    function automatic logic [31:0] pick_shift_register();
        logic [31:0] rs;
        rs = $urandom;
        case ($urandom_range(0, 7))
            0:       rs[7:0] = '0;
            1:       rs[7:0] = 8'd32;
            2:       rs[7:0] = 8'($urandom_range(1, 31));
            3:       rs[7:0] = 8'($urandom_range(33, 255));
            4:       rs[7:0] = 8'd64;
            default: ;
        endcase
        return rs;
    endfunction

    // Mostly supported opcodes; bias the immediate shift amount toward its zero encodings
    function automatic logic [31:0] random_instruction();
        logic [31:0] w;
        w = $urandom;
        if ($urandom_range(0, 9) != 0)
            w[24:21] = SUPPORTED_OPCODES[$urandom_range(0, 9)];
        if ($urandom_range(0, 3) == 0)
            w[11:7] = '0;
        return w;
    endfunction

    // Offer one instruction, wait for its transfer, then record the result it owes.
    // Valid stays high afterward so a gap-free next item rides straight on.
    task automatic send_instruction(input logic [31:0] instr, input logic [31:0] rn,
                                    input logic [31:0] rm, input logic [31:0] rs);
        int unsigned gap;
        gap = quiet_tx ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid                  <= 1'b1;
        instruction                 <= instr;
        first_operand_value         <= rn;
        shifted_register_value      <= rm;
        shift_amount_register_value <= rs;
        do
            @(posedge clk);
        while (item_stall);
        predicted_results.push_back(execute_instruction(instr, rn, rm, rs));
    endtask

    // Drop valid and hold until every owed result has come back
    task automatic drain_results();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (predicted_results.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every opcode value, including the unused ones, with immediate operand 2.
    // The rotation follows the opcode, so rotation zero (carry held) comes first.
    // S alternates, so test opcodes are seen with and without a flag update.
    task automatic test_opcodes();
        logic [3:0] opc;
        for (int op = 0; op < 16; op++)
        begin
            opc = 4'(op);
            send_instruction(dp_word(1'b1, opc, ~opc[0], opc, {opc, 8'h81}),
                             opc[1] ? 32'h0 : 32'hFFFF_FFFF, pick_operand(), pick_operand());
        end
        drain_results();
    endtask

    // Shifter corners, mostly through MOVS so the carry out lands in the flags
    task automatic test_shifter();
        // LSL #0 passes Rm and keeps C
        send_instruction(dp_word(1'b0, OPC_MOV, 1'b1, 4'd1, shift_by_imm(5'd0, SHT_LSL)),
                         pick_operand(), 32'h8000_0001, pick_operand());
        // LSR #0 means LSR #32: zero result, C from bit 31
        send_instruction(dp_word(1'b0, OPC_MOV, 1'b1, 4'd2, shift_by_imm(5'd0, SHT_LSR)),
                         pick_operand(), 32'h8000_0000, pick_operand());
        // ASR #0 means ASR #32: sign fill
        send_instruction(dp_word(1'b0, OPC_MOV, 1'b1, 4'd3, shift_by_imm(5'd0, SHT_ASR)),
                         pick_operand(), 32'h8000_0000, pick_operand());
        // ROR #0 is RRX: old C enters bit 31
        send_instruction(dp_word(1'b0, OPC_MOV, 1'b1, 4'd4, shift_by_imm(5'd0, SHT_ROR)),
                         pick_operand(), 32'h0000_0003, pick_operand());
        // Rs low byte zero: value and C pass untouched
        send_instruction(dp_word(1'b0, OPC_MOV, 1'b1, 4'd5, shift_by_reg(SHT_ROR)),
                         pick_operand(), 32'h1234_5678, 32'hFFFF_FF00);
        // LSL by exactly 32: zero, C from bit 0
        send_instruction(dp_word(1'b0, OPC_MOV, 1'b1, 4'd6, shift_by_reg(SHT_LSL)),
                         pick_operand(), 32'h0000_0001, 32'd32);
        // LSR beyond 32: zero with C clear
        send_instruction(dp_word(1'b0, OPC_MOV, 1'b1, 4'd7, shift_by_reg(SHT_LSR)),
                         pick_operand(), 32'hFFFF_FFFF, 32'd33);
        // ASR far beyond 32: sign fill, C from bit 31
        send_instruction(dp_word(1'b0, OPC_MOV, 1'b1, 4'd8, shift_by_reg(SHT_ASR)),
                         pick_operand(), 32'h8000_0000, 32'd200);
        // ROR by a nonzero multiple of 32: unchanged, C from bit 31
        send_instruction(dp_word(1'b0, OPC_MOV, 1'b1, 4'd9, shift_by_reg(SHT_ROR)),
                         pick_operand(), 32'h8000_0000, 32'd64);
        // Bit 7 and bit 4 both set: still a register-shifted operand
        send_instruction(dp_word(1'b0, OPC_ADD, 1'b1, 4'd10,
                                 {4'($urandom), 1'b1, SHT_LSR, 1'b1, 4'($urandom)}),
                         pick_operand(), pick_operand(), 32'd5);
        drain_results();
    endtask

    // Broad random mix; both sides drop their gaps for stretches, offset from each other
    task automatic test_random();
        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            quiet_tx = (k % 400) >= 300;
            quiet_rx = ((k + 150) % 400) >= 300;
            send_instruction(random_instruction(), pick_operand(), pick_operand(),
                             pick_shift_register());
        end
        drain_results();
        quiet_tx = 1'b0;
        quiet_rx = 1'b0;
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering back to back,
    // so the internal queue fills and item_stall rises
    task automatic test_backpressure();
        hold_off_request = 1'b1;
        quiet_tx         = 1'b1;
        repeat (PRESSURE_ITEMS)
            send_instruction(random_instruction(), pick_operand(), pick_operand(),
                             pick_shift_register());
        drain_results();
        quiet_tx = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Receiver: draw a stall length per result, or serve a long hold-off when asked
    // ------------------------------------------------------------------
    initial
    begin : receiver
        int unsigned gap;
        result_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_off_request)
            begin
                gap              = HOLD_OFF_CYCLES;
                hold_off_request = 1'b0;
            end
            else
                gap = quiet_rx ? 0 : $urandom_range(0, 7);
            if (gap > 0)
            begin
                result_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            result_stall <= 1'b0;
            // Stall is low from here on, so the first valid edge is a transfer
            do
                @(posedge clk);
            while (!result_valid);
        end
    end

    // ------------------------------------------------------------------
    // Result checking and watchdog
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        dp_result_t got;
        dp_result_t want;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                got = {result_value, dest_index, write_dest,
                       flag_negative, flag_zero, flag_carry, bad_opcode};
                if (predicted_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result transfer: value=%h rd=%0d",
                                 got.value, got.rd);
                end
                else
                begin
                    want = predicted_results.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display({"result mismatch: expected value=%h rd=%0d wr=%b ",
                                      "nzc=%b%b%b bad=%b, got value=%h rd=%0d wr=%b ",
                                      "nzc=%b%b%b bad=%b"},
                                     want.value, want.rd, want.write, want.neg, want.zero,
                                     want.carry, want.bad, got.value, got.rd, got.write,
                                     got.neg, got.zero, got.carry, got.bad);
                    end
                end
            end
            // Count edges where neither side completes a transfer
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[arm_data_processing_unit] ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n                       <= 1'b0;
        item_valid                  <= 1'b0;
        instruction                 <= '0;
        first_operand_value         <= '0;
        shifted_register_value      <= '0;
        shift_amount_register_value <= '0;
        nzc_flags        = '0;
        mismatches       = 0;
        idle_cycles      = 0;
        hold_off_request = 1'b0;
        quiet_tx         = 1'b0;
        quiet_rx         = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_opcodes();
        test_shifter();
        test_random();
        test_backpressure();

        // Let any stray result show up before judging
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && predicted_results.size() == 0)
            $display("[arm_data_processing_unit] OK");
        else
            $display("[arm_data_processing_unit] ERROR");
        $finish;
    end

endmodule
